/* sv/mjqc_pkg.sv */
`default_nettype none
package mjqc_pkg;
  localparam int InW       = 32;
  localparam int DurW      = 10;
  localparam int CoefW     = 64;
  localparam int QuotW     = 64;
  localparam int DenW      = 51;
  localparam int FrontLat  = 5;
  localparam int DIV_BPS_DEFAULT = 4;

  localparam logic signed [CoefW-1:0] CoefMax = {1'b0, {(CoefW-1){1'b1}}};
  localparam logic signed [CoefW-1:0] CoefMin = {1'b1, {(CoefW-1){1'b0}}};

  localparam int K10 = 10;
  localparam int K8  = 8;
  localparam int K15 = 15;
  localparam int K14 = 14;
  localparam int K6  = 6;
  localparam int K2  = 2;
endpackage
`default_nettype wire

/* sv/min_jerk_quintic_coefficients_core.sv */
// Channel  | Handshake        | Ports
// ---------+------------------+-----------------------------------------------
// input    | start, busy      | start_pos..end_acc, duration
// result   | done (strobe)    | coef0..coef5, invalid
//
// A word is accepted every cycle; busy is always low.
// Each result word passes the input registers, stages 1 to 4, the long-division pipeline,
// which retires DivBitsPerStage bits per stage, and the output registers.
// Reset is synchronous and clears only the valid bits of the pipeline.
// Nothing stalls: the receiver takes each result in the cycle it is shown.
`default_nettype none
module min_jerk_quintic_coefficients_core #(
  parameter int DivBitsPerStage = mjqc_pkg::DIV_BPS_DEFAULT
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic signed [mjqc_pkg::InW-1:0]      start_pos,
  input  wire logic signed [mjqc_pkg::InW-1:0]      start_vel,
  input  wire logic signed [mjqc_pkg::InW-1:0]      start_acc,
  input  wire logic signed [mjqc_pkg::InW-1:0]      end_pos,
  input  wire logic signed [mjqc_pkg::InW-1:0]      end_vel,
  input  wire logic signed [mjqc_pkg::InW-1:0]      end_acc,
  input  wire logic        [mjqc_pkg::DurW-1:0]     duration,
  output logic                                      done,
  output logic signed [mjqc_pkg::CoefW-1:0]         coef0,
  output logic signed [mjqc_pkg::CoefW-1:0]         coef1,
  output logic signed [mjqc_pkg::CoefW-1:0]         coef2,
  output logic signed [mjqc_pkg::CoefW-1:0]         coef3,
  output logic signed [mjqc_pkg::CoefW-1:0]         coef4,
  output logic signed [mjqc_pkg::CoefW-1:0]         coef5,
  output logic                                      invalid
);
  import mjqc_pkg::*;

  localparam int DivLat = QuotW / DivBitsPerStage + 2;

  assign busy = 1'b0;

  // Stage 0: input registers.
  logic                    v0;
  logic signed [InW-1:0]   p0_r, v0_r, a0_r, p1_r, v1_r, a1_r;
  logic [DurW-1:0]         t0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= start && !busy;
    end
    p0_r <= start_pos;
    v0_r <= start_vel;
    a0_r <= start_acc;
    p1_r <= end_pos;
    v1_r <= end_vel;
    a1_r <= end_acc;
    t0   <= duration;
  end

  // Stage 1.
  logic                    v1;
  logic [DurW-1:0]         t1;
  logic [2*DurW-1:0]       t2_1;
  logic signed [42:0]      v0t_1, a0t_1;
  logic signed [32:0]      dp_1, dv0_1, da_1;
  logic signed [InW-1:0]   p0_1, v0_1, a0_1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= v0;
    end
    t1    <= t0;
    t2_1  <= t0 * t0;
    v0t_1 <= 43'(v0_r * $signed({1'b0, t0}));
    a0t_1 <= 43'(a0_r * $signed({1'b0, t0}));
    dp_1  <= 33'(p1_r) - 33'(p0_r);
    dv0_1 <= 33'(v1_r) - 33'(v0_r);
    da_1  <= 33'(a1_r) - 33'(a0_r);
    p0_1  <= p0_r;
    v0_1  <= v0_r;
    a0_1  <= a0_r;
  end

  // Stage 2.
  logic                    v2;
  logic [DurW-1:0]         t_2;
  logic [3*DurW-1:0]       t3_2;
  logic signed [52:0]      a0t2_2;
  logic signed [53:0]      dat2_2;
  logic signed [43:0]      dv_2;
  logic signed [32:0]      dp_2;
  logic signed [42:0]      v0t_2;
  logic signed [InW-1:0]   p0_2, v0_2, a0_2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    t_2    <= t1;
    t3_2   <= t2_1 * t1;
    a0t2_2 <= 53'(a0_1 * $signed({1'b0, t2_1}));
    dat2_2 <= 54'(da_1 * $signed({1'b0, t2_1}));
    dv_2   <= 44'(dv0_1) - 44'(a0t_1);
    dp_2   <= dp_1;
    v0t_2  <= v0t_1;
    p0_2   <= p0_1;
    v0_2   <= v0_1;
    a0_2   <= a0_1;
  end

  // Stage 3.
  logic                    v3;
  logic [DurW-1:0]         t_3;
  logic [3*DurW-1:0]       t3_3;
  logic [4*DurW-1:0]       t4_3;
  logic signed [54:0]      h2_3, dvt_3;
  logic signed [53:0]      dat2_3;
  logic signed [InW-1:0]   p0_3, v0_3, a0_3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    t_3    <= t_2;
    t3_3   <= t3_2;
    t4_3   <= t3_2 * t_2;
    h2_3   <= (55'(dp_2) <<< 1) - (55'(v0t_2) <<< 1) - 55'(a0t2_2);
    dvt_3  <= 55'(dv_2 * $signed({1'b0, t_2}));
    dat2_3 <= dat2_2;
    p0_3   <= p0_2;
    v0_3   <= v0_2;
    a0_3   <= a0_2;
  end

  // Stage 4: numerators and divisors.
  logic                    v4, inv4;
  logic signed [CoefW-1:0] n3_4, n4_4, n5_4;
  logic [DenW-1:0]         d3_4, d4_4, d5_4;
  logic signed [InW-1:0]   p0_4, v0_4, a0_4;
  logic signed [CoefW-1:0] h2w, dvtw, dat2w;

  assign h2w   = CoefW'(h2_3);
  assign dvtw  = CoefW'(dvt_3);
  assign dat2w = CoefW'(dat2_3);

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    inv4 <= t_3 == '0;
    n3_4 <= CoefW'(K10) * h2w - CoefW'(K8) * dvtw + dat2w;
    n4_4 <= CoefW'(K14) * dvtw - CoefW'(K15) * h2w - CoefW'(K2) * dat2w;
    n5_4 <= CoefW'(K6) * h2w - CoefW'(K6) * dvtw + dat2w;
    d3_4 <= DenW'({t3_3, 1'b0});
    d4_4 <= DenW'({t4_3, 1'b0});
    d5_4 <= DenW'({t4_3 * (5*DurW)'(t_3), 1'b0});
    p0_4 <= p0_3;
    v0_4 <= v0_3;
    a0_4 <= a0_3;
  end

  logic                    dv3, dv4, dv5;
  logic signed [CoefW-1:0] q3, q4, q5;

  mjqc_div #(.BitsPerStage(DivBitsPerStage)) u_div3 (
    .clk(clk), .rst(rst), .in_valid(v4), .in_num(n3_4), .in_den(d3_4),
    .out_valid(dv3), .out_q(q3)
  );
  mjqc_div #(.BitsPerStage(DivBitsPerStage)) u_div4 (
    .clk(clk), .rst(rst), .in_valid(v4), .in_num(n4_4), .in_den(d4_4),
    .out_valid(dv4), .out_q(q4)
  );
  mjqc_div #(.BitsPerStage(DivBitsPerStage)) u_div5 (
    .clk(clk), .rst(rst), .in_valid(v4), .in_num(n5_4), .in_den(d5_4),
    .out_valid(dv5), .out_q(q5)
  );

  // Side data travels alongside the dividers.
  logic                    sd_v   [0:DivLat-1];
  logic                    sd_inv [0:DivLat-1];
  logic signed [InW-1:0]   sd_p0  [0:DivLat-1];
  logic signed [InW-1:0]   sd_v0  [0:DivLat-1];
  logic signed [InW-1:0]   sd_a0  [0:DivLat-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      sd_v[0] <= 1'b0;
    end else begin
      sd_v[0] <= v4;
    end
    sd_inv[0] <= inv4;
    sd_p0[0]  <= p0_4;
    sd_v0[0]  <= v0_4;
    sd_a0[0]  <= a0_4;
  end

  for (genvar i = 1; i < DivLat; i++) begin : g_side
    always_ff @(posedge clk) begin
      if (rst) begin
        sd_v[i] <= 1'b0;
      end else begin
        sd_v[i] <= sd_v[i-1];
      end
      sd_inv[i] <= sd_inv[i-1];
      sd_p0[i]  <= sd_p0[i-1];
      sd_v0[i]  <= sd_v0[i-1];
      sd_a0[i]  <= sd_a0[i-1];
    end
  end

  logic out_inv;

  assign out_inv = sd_inv[DivLat-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= sd_v[DivLat-1] && dv3 && dv4 && dv5;
    end
    invalid <= out_inv;
    coef0 <= out_inv ? '0 : {sd_p0[DivLat-1], 32'b0};
    coef1 <= out_inv ? '0 : {sd_v0[DivLat-1], 32'b0};
    coef2 <= out_inv ? '0 : {sd_a0[DivLat-1][InW-1], sd_a0[DivLat-1], 31'b0};
    coef3 <= out_inv ? '0 : q3;
    coef4 <= out_inv ? '0 : q4;
    coef5 <= out_inv ? '0 : q5;
  end
endmodule
`default_nettype wire

/* sv/mjqc_div.sv */
`default_nettype none
module mjqc_div #(
  parameter int BitsPerStage = mjqc_pkg::DIV_BPS_DEFAULT
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  input  wire logic signed [mjqc_pkg::CoefW-1:0]   in_num,
  input  wire logic        [mjqc_pkg::DenW-1:0]    in_den,
  output logic                                     out_valid,
  output logic signed [mjqc_pkg::CoefW-1:0]        out_q
);
  import mjqc_pkg::*;

  localparam int Stages = QuotW / BitsPerStage;

  logic                 vld  [0:Stages];
  logic                 neg  [0:Stages];
  logic                 sat  [0:Stages];
  logic [DenW-1:0]      den  [0:Stages];
  logic [DenW-1:0]      rem  [0:Stages];
  logic [QuotW-1:0]     quo  [0:Stages];
  logic [QuotW-1:0]     low  [0:Stages];

  logic             num_neg;
  logic [CoefW-1:0] num_mag;

  assign num_neg = in_num[CoefW-1];
  assign num_mag = num_neg ? CoefW'(-in_num) : in_num;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
    neg[0] <= num_neg;
    sat[0] <= {{(DenW-CoefW+31){1'b0}}, num_mag[CoefW-1:31]} >= in_den;
    den[0] <= in_den;
    rem[0] <= DenW'(num_mag[61:31]);
    quo[0] <= '0;
    low[0] <= {num_mag[30:0], 33'b0};
  end

  for (genvar s = 0; s < Stages; s++) begin : g_stage
    logic [DenW:0]    rr;
    logic [DenW-1:0]  rw;
    logic [QuotW-1:0] qw;
    logic [QuotW-1:0] lw;
    logic             ge;

    always_comb begin
      rw = rem[s];
      qw = quo[s];
      lw = low[s];
      rr = '0;
      ge = 1'b0;
      for (int b = 0; b < BitsPerStage; b++) begin
        rr = {rw, lw[QuotW-1]};
        lw = {lw[QuotW-2:0], 1'b0};
        ge = rr >= {1'b0, den[s]};
        qw = {qw[QuotW-2:0], ge};
        if (ge) begin
          rw = DenW'(rr - {1'b0, den[s]});
        end else begin
          rw = rr[DenW-1:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else begin
        vld[s+1] <= vld[s];
      end
      neg[s+1] <= neg[s];
      sat[s+1] <= sat[s];
      den[s+1] <= den[s];
      rem[s+1] <= rw;
      quo[s+1] <= qw;
      low[s+1] <= lw;
    end
  end

  logic [QuotW-1:0] rnd;
  logic [CoefW-1:0] res;

  assign rnd = {1'b0, quo[Stages][QuotW-1:1]} + QuotW'(quo[Stages][0]);

  always_comb begin
    if (sat[Stages]) begin
      res = neg[Stages] ? CoefMin : CoefMax;
    end else if (neg[Stages]) begin
      res = CoefW'(-rnd);
    end else if (rnd[QuotW-1]) begin
      res = CoefMax;
    end else begin
      res = rnd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vld[Stages];
    end
    out_q <= res;
  end
endmodule
`default_nettype wire

/* sv/mjqc_checker.sv */
`default_nettype none
module mjqc_checker #(
  parameter int DivBitsPerStage = mjqc_pkg::DIV_BPS_DEFAULT
) (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               start,
  input wire logic                               busy,
  input wire logic signed [mjqc_pkg::InW-1:0]    start_pos,
  input wire logic        [mjqc_pkg::DurW-1:0]   duration,
  input wire logic                               done,
  input wire logic signed [mjqc_pkg::CoefW-1:0]  coef0,
  input wire logic signed [mjqc_pkg::CoefW-1:0]  coef5,
  input wire logic                               invalid
);
  import mjqc_pkg::*;

  localparam int Lat  = mjqc_pkg::FrontLat + 3 + QuotW / DivBitsPerStage;
  localparam int CntW = $clog2(Lat + 1);

  logic [CntW-1:0] warm;

  always_ff @(posedge clk) begin
    if (rst) begin
      warm <= '0;
    end else if (warm != CntW'(Lat)) begin
      warm <= warm + 1'b1;
    end
  end

  a_busy_low: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (warm == CntW'(Lat)) |-> (done == $past(start && !busy, Lat)))
    else $error("result word not at fixed latency");

  a_invalid: assert property (@(posedge clk) disable iff (rst)
    (warm == CntW'(Lat) && done) |-> (invalid == ($past(duration, Lat) == '0)))
    else $error("invalid flag does not follow duration");

  a_coef0: assert property (@(posedge clk) disable iff (rst)
    (warm == CntW'(Lat) && done && !invalid) |->
      (coef0 == {$past(start_pos, Lat), 32'b0}))
    else $error("constant term does not match start position");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    (done && invalid) |-> (coef0 == '0 && coef5 == '0))
    else $error("invalid word carries nonzero coefficients");
endmodule

bind min_jerk_quintic_coefficients_core mjqc_checker #(
  .DivBitsPerStage(DivBitsPerStage)
) u_mjqc_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .start_pos(start_pos),
  .duration(duration), .done(done), .coef0(coef0), .coef5(coef5),
  .invalid(invalid)
);
`default_nettype wire
